FILE: rtl/dtt_pkg.sv
// Package for the debounced toggle with timeout block.
// Holds widths, register indexes, debouncer phase codes and the divide-by-1000 constants.
// No dependencies; every other file imports it.
`default_nettype none

package dtt_pkg;

    localparam int TIME_W   = 32;
    localparam int COUNT_W  = 32;
    localparam int REMAIN_W = 15;
    localparam int RUN_W    = 9;
    localparam int PHASE_W  = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    // Width of the rounded-up millisecond figure that is divided by 1000
    localparam int ROUND_W = 25;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LOCKOUT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_STUCK    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_AUTO_OFF = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BLINK    = 3'd4;

    // Debouncer phases; the fourth code behaves as idle
    localparam logic [PHASE_W-1:0] PH_IDLE    = 2'd0;
    localparam logic [PHASE_W-1:0] PH_PRESSED = 2'd1;
    localparam logic [PHASE_W-1:0] PH_WAIT    = 2'd2;

    localparam logic [RUN_W-1:0] RUN_MAX = 9'd511;

    localparam int MS_ROUND_UP = 999;
    localparam int MS_PER_S    = 1000;

    // floor(x / 1000) = (x * DIV_MULT) >> DIV_SHIFT, exact for x below 2**ROUND_W
    localparam int DIV_SHIFT = ROUND_W + 10;
    localparam int MULT_W    = 26;
    localparam int PROD_W    = ROUND_W + MULT_W;
    localparam longint DIV_MULT_FULL =
        ((longint'(1) <<< DIV_SHIFT) + longint'(MS_PER_S) - 1) / longint'(MS_PER_S);
    localparam logic [MULT_W-1:0] DIV_MULT = MULT_W'(DIV_MULT_FULL);

    // Reset values of the configuration registers
    localparam logic [7:0]  RST_DEBOUNCE = 8'd3;
    localparam logic [15:0] RST_LOCKOUT  = 16'd50;
    localparam logic [23:0] RST_STUCK    = 24'd3000;
    localparam logic [23:0] RST_AUTO_OFF = 24'd10000;
    localparam logic [15:0] RST_BLINK    = 16'd500;

endpackage

`default_nettype wire

FILE: rtl/dtt_sample_if.sv
// Input channel of the debounced toggle block: one button sample word.
// Depends on dtt_pkg for the field widths.
`default_nettype none

interface dtt_sample_if
    import dtt_pkg::*;
();
    logic              valid;
    logic              ready;
    logic              btn_pressed;
    logic [TIME_W-1:0] time_ms;

    modport source (output valid, output btn_pressed, output time_ms, input ready);
    modport sink   (input valid, input btn_pressed, input time_ms, output ready);
endinterface

`default_nettype wire

FILE: rtl/dtt_result_if.sv
// Output channel of the debounced toggle block: one result word per sample.
// Depends on dtt_pkg for the field widths.
`default_nettype none

interface dtt_result_if
    import dtt_pkg::*;
();
    logic                valid;
    logic                ready;
    logic                led_on;
    logic                press_fired;
    logic                stuck;
    logic                blink_out;
    logic                auto_off;
    logic [COUNT_W-1:0]  press_total;
    logic [REMAIN_W-1:0] remain_s;

    modport source (output valid, output led_on, output press_fired, output stuck,
                    output blink_out, output auto_off, output press_total,
                    output remain_s, input ready);
    modport sink   (input valid, input led_on, input press_fired, input stuck,
                    input blink_out, input auto_off, input press_total,
                    input remain_s, output ready);
endinterface

`default_nettype wire

FILE: rtl/dtt_cfg_if.sv
// Configuration write channel of the debounced toggle block.
// Depends on dtt_pkg for the index and data widths.
`default_nettype none

interface dtt_cfg_if
    import dtt_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

FILE: rtl/debounced_toggle_with_timeout_top.sv
// Top level of the debounced toggle with timeout block: debouncer, toggle, auto off and blink.
// Depends on dtt_pkg and the interfaces dtt_sample_if, dtt_result_if and dtt_cfg_if.
//
//   channel  | direction | word carried
//   ---------+-----------+------------------------------------------------------------
//   sample   | in        | btn_pressed, time_ms
//   result   | out       | led_on, press_fired, stuck, blink_out, auto_off, press_total,
//            |           | remain_s
//   cfg      | in        | index, data (always ready)
//
// A sample word may be accepted on every clock while the pipeline has room. The pipeline is
// input register, state update stage, divide-by-1000 stage, output register. The loop through
// the debouncer and toggle state closes through its own state registers, which sets the rate
// at one word per cycle unless the result side stalls. A stalled result holds each stage in
// turn, and sample ready drops only once every stage is full. Reset clears all but data registers.
`default_nettype none

module debounced_toggle_with_timeout_top
    import dtt_pkg::*;
(
    input  wire           clk,
    input  wire           rst_n,
    dtt_sample_if.sink    sample,
    dtt_result_if.source  result,
    dtt_cfg_if.sink       cfg
);

    // ------------------------------------------------------------------
    // Configuration registers. Write them only while the block is idle; the block does not enforce it.
    // ------------------------------------------------------------------
    logic [7:0]  debounce_reg;
    logic [15:0] lockout_reg;
    logic [23:0] stuck_ms_reg;
    logic [23:0] auto_off_ms_reg;
    logic [15:0] blink_ms_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_reg    <= RST_DEBOUNCE;
            lockout_reg     <= RST_LOCKOUT;
            stuck_ms_reg    <= RST_STUCK;
            auto_off_ms_reg <= RST_AUTO_OFF;
            blink_ms_reg    <= RST_BLINK;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                REG_DEBOUNCE: debounce_reg    <= cfg.data[7:0];
                REG_LOCKOUT:  lockout_reg     <= cfg.data[15:0];
                REG_STUCK:    stuck_ms_reg    <= cfg.data[23:0];
                REG_AUTO_OFF: auto_off_ms_reg <= cfg.data[23:0];
                REG_BLINK:    blink_ms_reg    <= cfg.data[15:0];
                default:      ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Flow control. Each stage moves on when the one after it has room.
    // ------------------------------------------------------------------
    logic in_v_reg;
    logic mid_v_reg;
    logic out_v_reg;
    logic out_room;
    logic mid_room;
    logic in_room;
    logic adv_a;
    logic adv_b;

    assign out_room = !out_v_reg || result.ready;
    assign mid_room = !mid_v_reg || out_room;
    assign in_room  = !in_v_reg || mid_room;
    assign adv_a    = in_v_reg && mid_room;
    assign adv_b    = mid_v_reg && out_room;

    assign sample.ready = in_room;

    // Input register
    logic              in_btn_reg;
    logic [TIME_W-1:0] in_time_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_v_reg <= 1'b0;
        end
        else if (in_room)
        begin
            in_v_reg <= sample.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (sample.valid && in_room)
        begin
            in_btn_reg  <= sample.btn_pressed;
            in_time_reg <= sample.time_ms;
        end
    end

    // ------------------------------------------------------------------
    // Block state, updated when a word leaves the input register.
    // ------------------------------------------------------------------
    logic [PHASE_W-1:0] deb_phase_reg,     deb_phase_next;
    logic [RUN_W-1:0]   deb_run_reg,       deb_run_next;
    logic [TIME_W-1:0]  hold_start_reg,    hold_start_next;
    logic [TIME_W-1:0]  lockout_until_reg, lockout_until_next;
    logic [COUNT_W-1:0] presses_reg,       presses_next;
    logic               is_on_reg,         is_on_next;
    logic [TIME_W-1:0]  on_since_reg,      on_since_next;
    logic [TIME_W-1:0]  blink_mark_reg,    blink_mark_next;
    logic               blink_level_reg,   blink_level_next;

    logic               fired;
    logic               stuck_now;
    logic               timed_out;
    logic [ROUND_W-1:0] round_ms;

    // Debouncer: lockout first, then the three phases.
    always_comb
    begin
        logic [RUN_W-1:0]  run_inc;
        logic [TIME_W-1:0] held;

        deb_phase_next     = deb_phase_reg;
        deb_run_next       = deb_run_reg;
        hold_start_next    = hold_start_reg;
        lockout_until_next = lockout_until_reg;
        fired              = 1'b0;
        stuck_now          = 1'b0;
        run_inc            = (deb_run_reg < RUN_MAX) ? deb_run_reg + 9'd1 : deb_run_reg;
        held               = in_time_reg - hold_start_reg;

        if (in_time_reg < lockout_until_reg)
        begin
            deb_phase_next = PH_IDLE;
            deb_run_next   = '0;
        end
        else
        begin
            case (deb_phase_reg)
                PH_PRESSED:
                begin
                    if (in_btn_reg)
                    begin
                        deb_run_next = run_inc;
                        // A zero threshold confirms just like a threshold of one
                        if (run_inc >= {1'b0, debounce_reg})
                        begin
                            hold_start_next = in_time_reg;
                            deb_phase_next  = PH_WAIT;
                        end
                    end
                    else
                    begin
                        deb_run_next   = '0;
                        deb_phase_next = PH_IDLE;
                    end
                end
                PH_WAIT:
                begin
                    if (in_btn_reg)
                    begin
                        stuck_now = (held > {8'd0, stuck_ms_reg});
                    end
                    else
                    begin
                        // Release edge: the press fires and the lockout window opens
                        fired              = 1'b1;
                        lockout_until_next = in_time_reg + {16'd0, lockout_reg};
                        deb_run_next       = '0;
                        deb_phase_next     = PH_IDLE;
                    end
                end
                default:
                begin
                    deb_phase_next = PH_IDLE;
                    if (in_btn_reg)
                    begin
                        deb_run_next   = 9'd1;
                        deb_phase_next = PH_PRESSED;
                    end
                end
            endcase
        end
    end

    // Toggle, auto off and the blink level.
    always_comb
    begin
        logic              turn_on;
        logic              on_mid;
        logic [TIME_W-1:0] since_old;
        logic [TIME_W-1:0] elapsed;
        logic [TIME_W-1:0] blink_gap;

        presses_next  = presses_reg + (fired ? 32'd1 : 32'd0);
        turn_on       = fired && !is_on_reg;
        on_mid        = fired ? !is_on_reg : is_on_reg;
        on_since_next = turn_on ? in_time_reg : on_since_reg;
        since_old     = in_time_reg - on_since_reg;
        // A state entered this tick has seen no time yet
        elapsed       = turn_on ? '0 : since_old;
        timed_out     = on_mid && (elapsed >= {8'd0, auto_off_ms_reg});
        is_on_next    = on_mid && !timed_out;

        // While on, elapsed stays below auto_off_ms, so the difference fits 24 bits
        if (is_on_next)
        begin
            round_ms = {1'b0, auto_off_ms_reg} - {1'b0, elapsed[23:0]}
                       + ROUND_W'(MS_ROUND_UP);
        end
        else
        begin
            round_ms = '0;
        end

        blink_gap        = in_time_reg - blink_mark_reg;
        blink_mark_next  = blink_mark_reg;
        blink_level_next = 1'b0;
        if (stuck_now)
        begin
            blink_level_next = blink_level_reg;
            if (blink_gap >= {16'd0, blink_ms_reg})
            begin
                blink_mark_next  = in_time_reg;
                blink_level_next = !blink_level_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            deb_phase_reg     <= PH_IDLE;
            deb_run_reg       <= '0;
            hold_start_reg    <= '0;
            lockout_until_reg <= '0;
            presses_reg       <= '0;
            is_on_reg         <= 1'b0;
            on_since_reg      <= '0;
            blink_mark_reg    <= '0;
            blink_level_reg   <= 1'b0;
        end
        else if (adv_a)
        begin
            deb_phase_reg     <= deb_phase_next;
            deb_run_reg       <= deb_run_next;
            hold_start_reg    <= hold_start_next;
            lockout_until_reg <= lockout_until_next;
            presses_reg       <= presses_next;
            is_on_reg         <= is_on_next;
            on_since_reg      <= on_since_next;
            blink_mark_reg    <= blink_mark_next;
            blink_level_reg   <= blink_level_next;
        end
    end

    // ------------------------------------------------------------------
    // Middle register: flags and the rounded-up milliseconds.
    // ------------------------------------------------------------------
    logic               mid_led_reg;
    logic               mid_press_reg;
    logic               mid_stuck_reg;
    logic               mid_blink_reg;
    logic               mid_auto_off_reg;
    logic [COUNT_W-1:0] mid_total_reg;
    logic [ROUND_W-1:0] mid_round_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mid_v_reg <= 1'b0;
        end
        else if (mid_room)
        begin
            mid_v_reg <= in_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv_a)
        begin
            mid_led_reg      <= is_on_next;
            mid_press_reg    <= fired;
            mid_stuck_reg    <= stuck_now;
            mid_blink_reg    <= blink_level_next;
            mid_auto_off_reg <= timed_out;
            mid_total_reg    <= presses_next;
            mid_round_reg    <= round_ms;
        end
    end

    // ------------------------------------------------------------------
    // Divide by 1000 through a constant reciprocal, then the output register.
    // ------------------------------------------------------------------
    logic [PROD_W-1:0] div_prod;

    assign div_prod = PROD_W'(mid_round_reg) * PROD_W'(DIV_MULT);

    logic                out_led_reg;
    logic                out_press_reg;
    logic                out_stuck_reg;
    logic                out_blink_reg;
    logic                out_auto_off_reg;
    logic [COUNT_W-1:0]  out_total_reg;
    logic [REMAIN_W-1:0] out_remain_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v_reg <= 1'b0;
        end
        else if (out_room)
        begin
            out_v_reg <= mid_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv_b)
        begin
            out_led_reg      <= mid_led_reg;
            out_press_reg    <= mid_press_reg;
            out_stuck_reg    <= mid_stuck_reg;
            out_blink_reg    <= mid_blink_reg;
            out_auto_off_reg <= mid_auto_off_reg;
            out_total_reg    <= mid_total_reg;
            out_remain_reg   <= div_prod[DIV_SHIFT +: REMAIN_W];
        end
    end

    assign result.valid       = out_v_reg;
    assign result.led_on      = out_led_reg;
    assign result.press_fired = out_press_reg;
    assign result.stuck       = out_stuck_reg;
    assign result.blink_out   = out_blink_reg;
    assign result.auto_off    = out_auto_off_reg;
    assign result.press_total = out_total_reg;
    assign result.remain_s    = out_remain_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------

    // The blink level can only be high while a confirmed press is held.
    a_blink_needs_wait: assert property (@(posedge clk) disable iff (!rst_n)
        blink_level_reg |-> deb_phase_reg == PH_WAIT)
        else $error("blink level set outside the waiting phase");

    // A timeout always leaves the state off.
    a_auto_off_is_off: assert property (@(posedge clk) disable iff (!rst_n)
        mid_v_reg && mid_auto_off_reg |-> !mid_led_reg)
        else $error("auto off reported while the state is on");

    // The press counter moves up by one whenever a press fires.
    a_press_count: assert property (@(posedge clk) disable iff (!rst_n)
        adv_a && fired |=> presses_reg == $past(presses_reg) + 32'd1)
        else $error("press counter did not step on a fired press");

    // A word held in the middle stage stays put while the output is blocked.
    a_mid_holds: assert property (@(posedge clk) disable iff (!rst_n)
        mid_v_reg && !out_room |=> mid_v_reg && $stable(mid_round_reg)
            && $stable(mid_total_reg))
        else $error("middle stage changed while stalled");

endmodule

`default_nettype wire

FILE: test/dtt_checker.sv
// Checker for the debounced toggle with timeout block: it watches the sample, result and
// configuration channels, predicts every result word and compares it field by field.
// Depends on dtt_pkg and the interfaces dtt_sample_if, dtt_result_if and dtt_cfg_if.
`default_nettype none

module dtt_checker
    import dtt_pkg::*;
(
    input  wire         clk,
    input  wire         rst_n,
    dtt_sample_if       sample,
    dtt_result_if       result,
    dtt_cfg_if          cfg,
    output int unsigned fails,
    output int unsigned outstanding
);

    typedef struct {
        logic                led_on;
        logic                press_fired;
        logic                stuck;
        logic                blink_out;
        logic                auto_off;
        logic [COUNT_W-1:0]  press_total;
        logic [REMAIN_W-1:0] remain_s;
    } tick_result_t;

    // Register copies
    logic [7:0]          need_samples;
    logic [15:0]         lockout_ms;
    logic [23:0]         stuck_ms;
    logic [23:0]         auto_off_ms;
    logic [15:0]         blink_ms;

    // Debouncer, toggle and blink state
    logic [PHASE_W-1:0]  phase;
    logic [RUN_W-1:0]    run;
    logic [TIME_W-1:0]   hold_start;
    logic [TIME_W-1:0]   lockout_until;
    logic [COUNT_W-1:0]  presses;
    logic                is_on;
    logic [TIME_W-1:0]   on_since;
    logic [TIME_W-1:0]   blink_mark;
    logic                blink_level;

    tick_result_t        expected_words[$];
    tick_result_t        want;
    int unsigned         mismatch_count;

    function automatic tick_result_t predict_tick(input logic pressed,
                                                  input logic [TIME_W-1:0] now);
        logic              fired;
        logic              held_long;
        logic              timed_out;
        logic [TIME_W-1:0] left_ms;
        tick_result_t      r;
        fired     = 1'b0;
        held_long = 1'b0;
        timed_out = 1'b0;

        // Samples inside the lockout window are ignored and the debouncer falls back to idle.
        if (now < lockout_until)
        begin
            phase = PH_IDLE;
            run   = '0;
        end
        else if (phase == PH_PRESSED)
        begin
            if (pressed)
            begin
                if (run != RUN_MAX)
                    run = run + 1'b1;
                if (run >= {1'b0, need_samples})
                begin
                    hold_start = now;
                    phase      = PH_WAIT;
                end
            end
            else
            begin
                run   = '0;
                phase = PH_IDLE;
            end
        end
        else if (phase == PH_WAIT)
        begin
            if (pressed)
                held_long = (now - hold_start) > stuck_ms;
            else
            begin
                presses       = presses + 1'b1;
                lockout_until = now + lockout_ms;
                run           = '0;
                phase         = PH_IDLE;
                fired         = 1'b1;
            end
        end
        else
        begin
            phase = PH_IDLE;
            if (pressed)
            begin
                run   = RUN_W'(1);
                phase = PH_PRESSED;
            end
        end

        if (fired)
        begin
            if (!is_on)
            begin
                is_on    = 1'b1;
                on_since = now;
            end
            else
                is_on = 1'b0;
        end
        if (is_on && (now - on_since) >= auto_off_ms)
        begin
            is_on     = 1'b0;
            timed_out = 1'b1;
        end

        if (held_long)
        begin
            if ((now - blink_mark) >= blink_ms)
            begin
                blink_mark  = now;
                blink_level = ~blink_level;
            end
        end
        else
            blink_level = 1'b0;

        left_ms       = auto_off_ms - (now - on_since);
        r.led_on      = is_on;
        r.press_fired = fired;
        r.stuck       = held_long;
        r.blink_out   = blink_level;
        r.auto_off    = timed_out;
        r.press_total = presses;
        r.remain_s    = is_on ? REMAIN_W'((left_ms + MS_ROUND_UP) / MS_PER_S) : '0;
        return r;
    endfunction

    task automatic check_field(input string field, input logic [31:0] want_v,
                               input logic [31:0] got_v);
        if (want_v !== got_v)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want_v, got_v);
            mismatch_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            need_samples   = RST_DEBOUNCE;
            lockout_ms     = RST_LOCKOUT;
            stuck_ms       = RST_STUCK;
            auto_off_ms    = RST_AUTO_OFF;
            blink_ms       = RST_BLINK;
            phase          = PH_IDLE;
            run            = '0;
            hold_start     = '0;
            lockout_until  = '0;
            presses        = '0;
            is_on          = 1'b0;
            on_since       = '0;
            blink_mark     = '0;
            blink_level    = 1'b0;
            mismatch_count = 0;
            expected_words.delete();
            fails          <= 0;
            outstanding    <= 0;
        end
        else
        begin
            if (result.valid && result.ready)
            begin
                if (expected_words.size() == 0)
                begin
                    $display("%0t: result word with nothing expected, actual press_total %0h",
                             $time, result.press_total);
                    mismatch_count++;
                end
                else
                begin
                    want = expected_words.pop_front();
                    check_field("led_on",      32'(want.led_on),      32'(result.led_on));
                    check_field("press_fired", 32'(want.press_fired), 32'(result.press_fired));
                    check_field("stuck",       32'(want.stuck),       32'(result.stuck));
                    check_field("blink_out",   32'(want.blink_out),   32'(result.blink_out));
                    check_field("auto_off",    32'(want.auto_off),    32'(result.auto_off));
                    check_field("press_total", want.press_total,      result.press_total);
                    check_field("remain_s",    32'(want.remain_s),    32'(result.remain_s));
                end
            end

            if (cfg.valid && cfg.ready)
            begin
                case (cfg.index)
                    REG_DEBOUNCE: need_samples = cfg.data[7:0];
                    REG_LOCKOUT:  lockout_ms   = cfg.data[15:0];
                    REG_STUCK:    stuck_ms     = cfg.data[23:0];
                    REG_AUTO_OFF: auto_off_ms  = cfg.data[23:0];
                    REG_BLINK:    blink_ms     = cfg.data[15:0];
                    default:      ;
                endcase
            end

            if (sample.valid && sample.ready)
                expected_words.push_back(predict_tick(sample.btn_pressed, sample.time_ms));

            outstanding <= expected_words.size();
            fails       <= mismatch_count;
        end
    end

endmodule

`default_nettype wire

FILE: test/tb_debounced_toggle_with_timeout_top.sv
// Testbench top for the debounced toggle with timeout block: clock, reset, sample stimulus,
// register writes, result back-pressure, watchdog and the final verdict.
// Depends on dtt_pkg, the three channel interfaces, the block itself and dtt_checker.
`default_nettype none

module tb_debounced_toggle_with_timeout_top
    import dtt_pkg::*;
();

    // Cycles without any accepted word before the run is declared hung. The slowest
    // legitimate stretch is the long result hold-off plus the longest sender gap.
    localparam int WATCHDOG_LIMIT   = 5000;
    localparam int LONG_HOLD_CYCLES = 300;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    dtt_sample_if sample();
    dtt_result_if result();
    dtt_cfg_if    cfg();

    int unsigned fail_count;
    int unsigned outstanding;

    debounced_toggle_with_timeout_top u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .sample (sample),
        .result (result),
        .cfg    (cfg)
    );

    dtt_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .sample      (sample),
        .result      (result),
        .cfg         (cfg),
        .fails       (fail_count),
        .outstanding (outstanding)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Sender state: the running millisecond clock, the words left in the current burst and
    // a count of sample words sent so far, which paces the random phases.
    logic [TIME_W-1:0] now_ms      = '0;
    int unsigned       burst_left  = 0;
    int unsigned       items_sent  = 0;

    // Register values currently in force, masked to their widths; the random phases use
    // them to shape press lengths and time steps.
    int unsigned       deb_now     = 32'(RST_DEBOUNCE);
    int unsigned       lock_now    = 32'(RST_LOCKOUT);

    // Each increment asks the receiver for one long hold-off.
    int unsigned       hold_requests = 0;

    // ------------------------------------------------------------------
    // Receiver: ready follows a pattern that is picked anew when its run ends, from always
    // ready through random stalls to a fixed one-in-four stall. A hold-off request drops
    // ready for a long stretch so that the pipeline fills and the sample side stalls.
    // ------------------------------------------------------------------
    int unsigned hold_seen  = 0;
    int unsigned hold_left  = 0;
    int unsigned rx_mode    = 0;
    int unsigned mode_left  = 0;
    int unsigned rx_count   = 0;

    always @(posedge clk)
    begin
        if (!rst_n)
            result.ready <= 1'b0;
        else if (hold_seen != hold_requests)
        begin
            hold_seen    <= hold_requests;
            hold_left    <= LONG_HOLD_CYCLES;
            result.ready <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left    <= hold_left - 1;
            result.ready <= 1'b0;
        end
        else
        begin
            rx_count <= rx_count + 1;
            if (mode_left == 0)
            begin
                rx_mode   <= $urandom_range(0, 3);
                mode_left <= $urandom_range(32, 400);
            end
            else
                mode_left <= mode_left - 1;
            case (rx_mode)
                0:       result.ready <= 1'b1;
                1:       result.ready <= 1'($urandom_range(0, 1));
                2:       result.ready <= (rx_count[1:0] != 2'd0);
                default: result.ready <= ($urandom_range(0, 9) != 0);
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: any accepted word on any channel restarts the count.
    // ------------------------------------------------------------------
    int unsigned idle_cycles = 0;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((sample.valid && sample.ready) || (result.valid && result.ready) ||
                (cfg.valid && cfg.ready))
                idle_cycles <= 0;
            else if (idle_cycles == WATCHDOG_LIMIT)
            begin
                $display("CHECK FAILED");
                $finish;
            end
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    // Advances the millisecond clock by a random step of up to step_ms, wrapping at 32 bits.
    function automatic logic [TIME_W-1:0] advance_ms(input int unsigned step_ms);
        now_ms = now_ms + $urandom_range(0, step_ms);
        return now_ms;
    endfunction

    // Offers one sample word and returns at the clock edge that accepts it. Words go out in
    // bursts; valid is dropped between bursts.
    task automatic offer_sample(input logic pressed, input logic [TIME_W-1:0] at_ms);
        int unsigned gap;
        if (burst_left == 0)
        begin
            sample.valid <= 1'b0;
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 6);
            repeat (gap) @(posedge clk);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                     : $urandom_range(1, 30);
        end
        sample.valid       <= 1'b1;
        sample.btn_pressed <= pressed;
        sample.time_ms     <= at_ms;
        @(posedge clk);
        while (sample.ready !== 1'b1)
            @(posedge clk);
        burst_left--;
        items_sent++;
    endtask

    // Stops the sender and waits until every predicted result word has come back. The
    // checker's count is registered, so the task waits for the next edge before it trusts it.
    task automatic drain_results();
        sample.valid <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= value;
        @(posedge clk);
        while (cfg.ready !== 1'b1)
            @(posedge clk);
    endtask

    // Writes all five registers. Bits above a register's width may carry junk, which the
    // block is expected to discard.
    task automatic apply_settings(input logic [CFG_DATA_W-1:0] deb_word, lock_word,
                                  stuck_word, auto_word, blink_word);
        write_reg(REG_DEBOUNCE, deb_word);
        write_reg(REG_LOCKOUT,  lock_word);
        write_reg(REG_STUCK,    stuck_word);
        write_reg(REG_AUTO_OFF, auto_word);
        write_reg(REG_BLINK,    blink_word);
        cfg.valid <= 1'b0;
        deb_now  = 32'(deb_word[7:0]);
        lock_now = 32'(lock_word[15:0]);
    endtask

    // Random traffic for one register setting. Most of it is whole presses: a few released
    // samples, a run of pressed samples around the debounce threshold (sometimes a long hold
    // that goes stuck), the release, and then either a wait past the lockout window or more
    // presses inside it. The rest is random noise and jumps of the clock, some of them to
    // just below the 32-bit wrap.
    task automatic run_random(input int unsigned n_items, input int unsigned step_ms);
        int unsigned target;
        int unsigned need;
        int unsigned held;
        int unsigned kind;
        target = items_sent + n_items;
        need   = (deb_now == 0) ? 2 : deb_now;
        while (items_sent < target)
        begin
            kind = $urandom_range(0, 99);
            if (kind < 70)
            begin
                repeat ($urandom_range(0, 3))
                    offer_sample(1'b0, advance_ms(step_ms));
                case ($urandom_range(0, 9))
                    0, 1:    held = $urandom_range(1, need);
                    2, 3, 4: held = need + $urandom_range(4, 30);
                    default: held = need + $urandom_range(0, 3);
                endcase
                repeat (held)
                    offer_sample(1'b1, advance_ms(step_ms));
                offer_sample(1'b0, advance_ms(step_ms));
                if ($urandom_range(0, 9) < 7)
                    now_ms = now_ms + lock_now + $urandom_range(0, step_ms);
                else
                    repeat ($urandom_range(1, 4))
                        offer_sample(1'($urandom_range(0, 1)), advance_ms(2));
            end
            else if (kind < 90)
            begin
                repeat ($urandom_range(1, 8))
                    offer_sample(1'($urandom_range(0, 1)), advance_ms(step_ms));
            end
            else
            begin
                if ($urandom_range(0, 1) == 0)
                    now_ms = 32'hFFFF_FFFF - $urandom_range(0, 4 * step_ms);
                else
                    now_ms = $urandom;
                offer_sample(1'($urandom_range(0, 1)), now_ms);
            end
        end
    endtask

    initial
    begin
        sample.valid       <= 1'b0;
        sample.btn_pressed <= 1'b0;
        sample.time_ms     <= '0;
        cfg.valid          <= 1'b0;
        cfg.index          <= REG_DEBOUNCE;
        cfg.data           <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed words under the reset settings (three samples, 50 ms lockout, 3 s stuck,
        // 10 s auto off, 500 ms blink). A press confirmed at 3 ms and held until 5 s goes
        // stuck and starts to blink; its release turns the light on.
        offer_sample(1'b0, 32'd0);
        offer_sample(1'b1, 32'd1);
        offer_sample(1'b1, 32'd2);
        offer_sample(1'b1, 32'd3);
        offer_sample(1'b1, 32'd5000);
        offer_sample(1'b0, 32'd5002);
        // Inside the lockout window, then exactly at its end: a second press turns it off.
        offer_sample(1'b1, 32'd5010);
        offer_sample(1'b1, 32'd5052);
        offer_sample(1'b1, 32'd5053);
        offer_sample(1'b1, 32'd5054);
        offer_sample(1'b0, 32'd5055);
        // A third press turns it on, and exactly 10 s later it switches itself off.
        offer_sample(1'b1, 32'd5200);
        offer_sample(1'b1, 32'd5201);
        offer_sample(1'b1, 32'd5202);
        offer_sample(1'b0, 32'd5203);
        offer_sample(1'b0, 32'd15203);
        // A press released just below the wrap: the lockout end wraps to a small value, so
        // the next top-of-range sample is not locked out while the one after the wrap is.
        offer_sample(1'b1, 32'hFFFF_FFF0);
        offer_sample(1'b1, 32'hFFFF_FFF1);
        offer_sample(1'b1, 32'hFFFF_FFF2);
        offer_sample(1'b0, 32'hFFFF_FFF3);
        offer_sample(1'b1, 32'hFFFF_FFFF);
        offer_sample(1'b0, 32'd0);
        drain_results();

        // All registers at zero: the second pressed sample confirms, any hold counts as stuck,
        // the blink toggles on every stuck sample and the light goes off as it comes on.
        apply_settings(24'd0, 24'd0, 24'd0, 24'd0, 24'd0);
        offer_sample(1'b1, 32'd100);
        offer_sample(1'b1, 32'd101);
        offer_sample(1'b1, 32'd102);
        offer_sample(1'b0, 32'd103);
        now_ms = 32'd103;
        drain_results();

        // Reset values written back, with one long result hold-off while words keep coming.
        apply_settings(CFG_DATA_W'(RST_DEBOUNCE), CFG_DATA_W'(RST_LOCKOUT),
                       CFG_DATA_W'(RST_STUCK), CFG_DATA_W'(RST_AUTO_OFF),
                       CFG_DATA_W'(RST_BLINK));
        hold_requests <= hold_requests + 1;
        run_random(300, 400);
        drain_results();

        // Lowest useful settings.
        apply_settings(24'd1, 24'd0, 24'd0, 24'd0, 24'd1);
        run_random(250, 3);
        drain_results();

        // Highest settings, with large time steps so that holds still go stuck.
        apply_settings(24'hFF_FFFF, 24'hFF_FFFF, 24'hFF_FFFF, 24'hFF_FFFF, 24'hFF_FFFF);
        run_random(600, 200000);
        drain_results();

        // A few random settings, junk in the unused upper bits of the narrow registers.
        repeat (4)
        begin
            automatic logic [23:0] deb_word   = {16'($urandom), 8'($urandom_range(0, 6))};
            automatic logic [23:0] lock_word  = {8'($urandom), 16'($urandom_range(0, 300))};
            automatic logic [23:0] stuck_word = 24'($urandom_range(0, 4000));
            automatic logic [23:0] auto_word  = 24'($urandom_range(0, 20000));
            automatic logic [23:0] blink_word = {8'($urandom), 16'($urandom_range(0, 600))};
            apply_settings(deb_word, lock_word, stuck_word, auto_word, blink_word);
            run_random(150, 32'((stuck_word + blink_word[15:0]) / 6 + 5));
            drain_results();
        end

        // Let the pipeline settle before the verdict.
        repeat (10) @(posedge clk);
        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

`default_nettype wire
